FILE: hdl/pvsm_pkg.sv
// ----------------------------------------------------------------------------
// pvsm_pkg: shared constants, types and functions
// Field widths, the octant sine/cosine table builder and the saturating add
// used by the polar vector sum block and its channel interfaces.
// ----------------------------------------------------------------------------
package pvsm_pkg;

  // field widths
  localparam int MAG_WIDTH      = 16;
  localparam int ANGLE_BITS     = 12;
  localparam int SUM_WIDTH      = 24;
  localparam int TRIG_FRAC_BITS = 15;

  // derived widths
  localparam int TRIG_W     = TRIG_FRAC_BITS + 1;
  localparam int TRIG_ROM_W = 2 * TRIG_W;
  localparam int IDX_W      = ANGLE_BITS - 2;
  localparam int TRIG_DEPTH = (2 ** (ANGLE_BITS - 3)) + 1;
  localparam int PROD_W     = MAG_WIDTH + TRIG_W;
  localparam int RAD_W      = 2 * SUM_WIDTH;
  localparam int ADD_W      = ((SUM_WIDTH > MAG_WIDTH + 1) ? SUM_WIDTH : MAG_WIDTH + 1) + 1;
  localparam int MAX_STEPS  = (MAG_WIDTH > SUM_WIDTH) ? MAG_WIDTH : SUM_WIDTH;
  localparam int CNT_W      = $clog2(MAX_STEPS);

  // pi in Q28
  localparam longint unsigned PI_Q28 = 64'd843314857;

  // saturation limits at adder width
  localparam logic signed [ADD_W-1:0] SAT_HI =
    {{(ADD_W - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
  localparam logic signed [ADD_W-1:0] SAT_LO =
    {{(ADD_W - SUM_WIDTH + 1){1'b1}}, {(SUM_WIDTH - 1){1'b0}}};

  typedef logic [TRIG_ROM_W-1:0] trig_rom_t [TRIG_DEPTH];

  typedef struct packed {
    logic                        clip;
    logic signed [SUM_WIDTH-1:0] value;
  } sat_res_t;

  // shift-subtract quotient for the table build, dividends stay below 2^32
  function automatic longint unsigned div_small(longint unsigned num,
                                                longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int b = 31; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // sine and cosine of an octant step, taylor series in Q30, rounded to TRIG_W bits
  function automatic logic [TRIG_ROM_W-1:0] trig_entry(int unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned s;
    longint unsigned tc;
    longint unsigned c;
    longint unsigned k;
    longint unsigned s_rnd;
    longint unsigned c_rnd;
    x  = ((longint'(r) * PI_Q28) << 3) >> ANGLE_BITS;
    x2 = (x * x) >> 30;
    ts = x;
    s  = x;
    tc = 64'd1 << 30;
    c  = 64'd1 << 30;
    for (k = 1; k <= 6; k++) begin
      ts = div_small((ts * x2) >> 30, (2 * k) * (2 * k + 1));
      tc = div_small((tc * x2) >> 30, (2 * k - 1) * (2 * k));
      if (k[0]) begin
        s = s - ts;
        c = c - tc;
      end else begin
        s = s + ts;
        c = c + tc;
      end
    end
    s_rnd = (s + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    c_rnd = (c + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return {s_rnd[TRIG_W-1:0], c_rnd[TRIG_W-1:0]};
  endfunction

  // whole octant table, evaluated at elaboration
  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int i = 0; i < TRIG_DEPTH; i++) begin
      rom[i] = trig_entry(unsigned'(i));
    end
    return rom;
  endfunction

  // add a signed component to a running sum, clipping at the sum range
  function automatic sat_res_t sat_add(logic signed [SUM_WIDTH-1:0] acc,
                                       logic [MAG_WIDTH-1:0] p, logic neg);
    logic signed [ADD_W-1:0] a;
    logic signed [ADD_W-1:0] v;
    logic signed [ADD_W-1:0] s;
    sat_res_t res;
    a = ADD_W'(acc);
    v = $signed(ADD_W'(p));
    if (neg) begin
      v = -v;
    end
    s = a + v;
    if (s > SAT_HI) begin
      res.clip  = 1'b1;
      res.value = SAT_HI[SUM_WIDTH-1:0];
    end else if (s < SAT_LO) begin
      res.clip  = 1'b1;
      res.value = SAT_LO[SUM_WIDTH-1:0];
    end else begin
      res.clip  = 1'b0;
      res.value = s[SUM_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/pvsm_if.sv
// ----------------------------------------------------------------------------
// pvsm channel interfaces
// Valid/ready channels for vector words, result words and the config write.
// ----------------------------------------------------------------------------

// vector word channel
interface pvsm_in_if;
  logic                             valid;
  logic                             ready;
  logic                             starts_event;
  logic                             ends_event;
  logic [pvsm_pkg::MAG_WIDTH-1:0]   magnitude_in;
  logic [pvsm_pkg::ANGLE_BITS-1:0]  angle;

  modport source (output valid, starts_event, ends_event, magnitude_in, angle,
                  input ready);
  modport sink (input valid, starts_event, ends_event, magnitude_in, angle,
                output ready);
endinterface

// result word channel
interface pvsm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvsm_pkg::SUM_WIDTH-1:0] sum_x;
  logic signed [pvsm_pkg::SUM_WIDTH-1:0] sum_y;
  logic [pvsm_pkg::SUM_WIDTH-1:0]      total_magnitude;
  logic                                saturated;

  modport source (output valid, sum_x, sum_y, total_magnitude, saturated,
                  input ready);
  modport sink (input valid, sum_x, sum_y, total_magnitude, saturated,
                output ready);
endinterface

// config write channel
interface pvsm_cfg_if;
  logic valid;
  logic ready;
  logic ignore_base;

  modport source (output valid, ignore_base, input ready);
  modport sink (input valid, ignore_base, output ready);
endinterface

FILE: hdl/polar_vector_sum_magnitude.sv
// ----------------------------------------------------------------------------
// polar_vector_sum_magnitude
// Sums polar vectors of an event into saturating x/y totals and reports the
// totals with the floor of their euclidean length on the event's last word.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : vector words (starts_event, ends_event, magnitude_in, angle).
//            starts_event clears the sums and marks the base vector.
//   out_if : one result word per ends_event (sum_x, sum_y, total_magnitude,
//            saturated), held in an output register until taken.
//   cfg_if : ignore_base write, always ready; write only while the block idles.
// Processing steps:
//   a vector word is taken in an accept step, then one multiply step per
//   magnitude bit on separate shift-add units for x and y, then one saturating
//   add; no new word is taken until that is done. A base word skipped by
//   ignore_base skips the multiply and the add. A word with ends_event then runs
//   the bit-serial square of both sums, then one root bit per cycle.
// Reset clears sums, clip flag, ignore_base and the output valid flag. A
// stalled receiver only holds the result; the next event is accepted and runs
// up to its own result, which waits until the previous one is taken.
// ----------------------------------------------------------------------------
module polar_vector_sum_magnitude (
  input  logic        clk,
  input  logic        rst_n,
  pvsm_in_if.sink     in_if,
  pvsm_out_if.source  out_if,
  pvsm_cfg_if.sink    cfg_if
);

  localparam int MW  = pvsm_pkg::MAG_WIDTH;
  localparam int SW  = pvsm_pkg::SUM_WIDTH;
  localparam int TW  = pvsm_pkg::TRIG_W;
  localparam int IW  = pvsm_pkg::IDX_W;
  localparam int PW  = pvsm_pkg::PROD_W;
  localparam int RW  = pvsm_pkg::RAD_W;
  localparam int CW  = pvsm_pkg::CNT_W;
  localparam int TF  = pvsm_pkg::TRIG_FRAC_BITS;
  localparam int AB  = pvsm_pkg::ANGLE_BITS;

  localparam pvsm_pkg::trig_rom_t TRIG_ROM = pvsm_pkg::build_trig_rom();
  localparam logic [PW:0]   ROUND_HALF = (PW + 1)'(1) << (TF - 1);
  localparam logic [IW-1:0] OCT_HALF   = {1'b1, {(IW - 1){1'b0}}};
  localparam logic [IW:0]   QUAD_SIZE  = {1'b1, {IW{1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_PREP = 7'b0001000,
    S_SQR  = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  // control state
  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   ignore_base_r, ignore_base_nxt;
  logic signed [SW-1:0]   acc_x_r, acc_x_nxt;
  logic signed [SW-1:0]   acc_y_r, acc_y_nxt;
  logic                   clip_r, clip_nxt;

  // datapath
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   end_r, end_nxt;
  logic [1:0]             quad_r, quad_nxt;
  logic                   swap_r, swap_nxt;
  logic [2*TW-1:0]        rom_q_r;
  logic [MW-1:0]          mag_sh_r, mag_sh_nxt;
  logic [PW-1:0]          prod_x_r, prod_x_nxt;
  logic [PW-1:0]          prod_y_r, prod_y_nxt;
  logic [SW-1:0]          ax_r, ax_nxt, ay_r, ay_nxt;
  logic [SW-1:0]          ax_sh_r, ax_sh_nxt, ay_sh_r, ay_sh_nxt;
  logic [RW-1:0]          sq_r, sq_nxt;
  logic [RW-1:0]          rad_r, rad_nxt;
  logic [SW+1:0]          rem_r, rem_nxt;
  logic [SW-1:0]          root_r, root_nxt;
  logic signed [SW-1:0]   o_sum_x_r, o_sum_x_nxt;
  logic signed [SW-1:0]   o_sum_y_r, o_sum_y_nxt;
  logic [SW-1:0]          o_mag_r, o_mag_nxt;
  logic                   o_sat_r, o_sat_nxt;

  // combinational helpers
  logic                   in_fire;
  logic                   add_item;
  logic [IW-1:0]          oct_r;
  logic [IW:0]            oct_mirror;
  logic [IW-1:0]          rom_idx;
  logic                   fold_swap;
  logic [TW-1:0]          s_tab, c_tab, s0, c0;
  logic [TW-1:0]          tx_mag, ty_mag;
  logic                   tx_neg, ty_neg;
  logic [PW:0]            px_round, py_round;
  pvsm_pkg::sat_res_t     sat_x, sat_y;
  logic [SW+3:0]          rem_t, trial, rem_diff;
  logic [RW-1:0]          sq_step;

  assign in_fire      = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign add_item     = !(in_if.starts_event && ignore_base_r);

  // fold the angle into the first octant
  assign oct_r      = in_if.angle[IW-1:0];
  assign oct_mirror = QUAD_SIZE - {1'b0, oct_r};
  assign fold_swap  = (oct_r > OCT_HALF);
  assign rom_idx    = fold_swap ? oct_mirror[IW-1:0] : oct_r;

  // table read, data registered
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rom_q_r <= TRIG_ROM[rom_idx];
    end
  end

  // octant swap and quadrant symmetry
  assign s_tab = rom_q_r[2*TW-1:TW];
  assign c_tab = rom_q_r[TW-1:0];
  assign s0    = swap_r ? c_tab : s_tab;
  assign c0    = swap_r ? s_tab : c_tab;

  always_comb begin
    case (quad_r)
      2'd0: begin
        tx_mag = c0; tx_neg = 1'b0; ty_mag = s0; ty_neg = 1'b0;
      end
      2'd1: begin
        tx_mag = s0; tx_neg = 1'b1; ty_mag = c0; ty_neg = 1'b0;
      end
      2'd2: begin
        tx_mag = c0; tx_neg = 1'b1; ty_mag = s0; ty_neg = 1'b1;
      end
      default: begin
        tx_mag = s0; tx_neg = 1'b0; ty_mag = c0; ty_neg = 1'b1;
      end
    endcase
  end

  // component rounding and saturating sums
  assign px_round = {1'b0, prod_x_r} + ROUND_HALF;
  assign py_round = {1'b0, prod_y_r} + ROUND_HALF;
  assign sat_x = pvsm_pkg::sat_add(acc_x_r, px_round[TF +: MW], tx_neg);
  assign sat_y = pvsm_pkg::sat_add(acc_y_r, py_round[TF +: MW], ty_neg);

  // one partial-product row of x^2 + y^2
  assign sq_step = {sq_r[RW-2:0], 1'b0}
                 + (ax_sh_r[SW-1] ? RW'(ax_r) : '0)
                 + (ay_sh_r[SW-1] ? RW'(ay_r) : '0);

  // one digit of the restoring square root
  assign rem_t    = {rem_r, rad_r[RW-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};
  assign rem_diff = rem_t - trial;

  // next-state logic
  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r;
    ignore_base_nxt = ignore_base_r;
    acc_x_nxt       = acc_x_r;
    acc_y_nxt       = acc_y_r;
    clip_nxt        = clip_r;
    cnt_nxt         = cnt_r;
    end_nxt         = end_r;
    quad_nxt        = quad_r;
    swap_nxt        = swap_r;
    mag_sh_nxt      = mag_sh_r;
    prod_x_nxt      = prod_x_r;
    prod_y_nxt      = prod_y_r;
    ax_nxt          = ax_r;
    ay_nxt          = ay_r;
    ax_sh_nxt       = ax_sh_r;
    ay_sh_nxt       = ay_sh_r;
    sq_nxt          = sq_r;
    rad_nxt         = rad_r;
    rem_nxt         = rem_r;
    root_nxt        = root_r;
    o_sum_x_nxt     = o_sum_x_r;
    o_sum_y_nxt     = o_sum_y_r;
    o_mag_nxt       = o_mag_r;
    o_sat_nxt       = o_sat_r;

    // config write
    if (cfg_if.valid && cfg_if.ready) begin
      ignore_base_nxt = cfg_if.ignore_base;
    end

    // result handed off
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          end_nxt    = in_if.ends_event;
          quad_nxt   = in_if.angle[AB-1 -: 2];
          swap_nxt   = fold_swap;
          mag_sh_nxt = in_if.magnitude_in;
          prod_x_nxt = '0;
          prod_y_nxt = '0;
          cnt_nxt    = CW'(MW - 1);
          if (in_if.starts_event) begin
            acc_x_nxt = '0;
            acc_y_nxt = '0;
            clip_nxt  = 1'b0;
          end
          if (add_item) begin
            state_nxt = S_MUL;
          end else if (in_if.ends_event) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_MUL: begin
        // msb-first shift-add, one magnitude bit per cycle
        prod_x_nxt = {prod_x_r[PW-2:0], 1'b0} + (mag_sh_r[MW-1] ? PW'(tx_mag) : '0);
        prod_y_nxt = {prod_y_r[PW-2:0], 1'b0} + (mag_sh_r[MW-1] ? PW'(ty_mag) : '0);
        mag_sh_nxt = {mag_sh_r[MW-2:0], 1'b0};
        if (cnt_r == '0) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ACC: begin
        acc_x_nxt = sat_x.value;
        acc_y_nxt = sat_y.value;
        clip_nxt  = clip_r | sat_x.clip | sat_y.clip;
        state_nxt = end_r ? S_PREP : S_IDLE;
      end
      S_PREP: begin
        ax_nxt    = acc_x_r[SW-1] ? (~acc_x_r + 1'b1) : acc_x_r;
        ay_nxt    = acc_y_r[SW-1] ? (~acc_y_r + 1'b1) : acc_y_r;
        ax_sh_nxt = acc_x_r[SW-1] ? (~acc_x_r + 1'b1) : acc_x_r;
        ay_sh_nxt = acc_y_r[SW-1] ? (~acc_y_r + 1'b1) : acc_y_r;
        sq_nxt    = '0;
        cnt_nxt   = CW'(SW - 1);
        state_nxt = S_SQR;
      end
      S_SQR: begin
        sq_nxt    = sq_step;
        ax_sh_nxt = {ax_sh_r[SW-2:0], 1'b0};
        ay_sh_nxt = {ay_sh_r[SW-2:0], 1'b0};
        if (cnt_r == '0) begin
          rad_nxt   = sq_step;
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CW'(SW - 1);
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ROOT: begin
        rad_nxt = {rad_r[RW-3:0], 2'b00};
        if (rem_t >= trial) begin
          rem_nxt  = rem_diff[SW+1:0];
          root_nxt = {root_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_t[SW+1:0];
          root_nxt = {root_r[SW-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_EMIT: begin
        // load the output register once the previous word has left
        if (!out_valid_r || out_if.ready) begin
          o_sum_x_nxt   = acc_x_r;
          o_sum_y_nxt   = acc_y_r;
          o_mag_nxt     = root_r;
          o_sat_nxt     = clip_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      ignore_base_r <= 1'b0;
      acc_x_r       <= '0;
      acc_y_r       <= '0;
      clip_r        <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      ignore_base_r <= ignore_base_nxt;
      acc_x_r       <= acc_x_nxt;
      acc_y_r       <= acc_y_nxt;
      clip_r        <= clip_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    end_r     <= end_nxt;
    quad_r    <= quad_nxt;
    swap_r    <= swap_nxt;
    mag_sh_r  <= mag_sh_nxt;
    prod_x_r  <= prod_x_nxt;
    prod_y_r  <= prod_y_nxt;
    ax_r      <= ax_nxt;
    ay_r      <= ay_nxt;
    ax_sh_r   <= ax_sh_nxt;
    ay_sh_r   <= ay_sh_nxt;
    sq_r      <= sq_nxt;
    rad_r     <= rad_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    o_sum_x_r <= o_sum_x_nxt;
    o_sum_y_r <= o_sum_y_nxt;
    o_mag_r   <= o_mag_nxt;
    o_sat_r   <= o_sat_nxt;
  end

  // result word
  assign out_if.valid           = out_valid_r;
  assign out_if.sum_x           = o_sum_x_r;
  assign out_if.sum_y           = o_sum_y_r;
  assign out_if.total_magnitude = o_mag_r;
  assign out_if.saturated       = o_sat_r;

  // a skipped base word leaves the event at zero
  a_skip_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.starts_event && ignore_base_r)
      |=> (acc_x_r == '0 && acc_y_r == '0 && !clip_r))
    else $error("sums not cleared by skipped base word");

  // the clip flag only drops on a start word or reset
  a_clip_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clip_r) |-> ($past(in_fire && in_if.starts_event) || !$past(rst_n)))
    else $error("clip flag cleared outside event start");

  // a new result only comes from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result word raised outside emit step");

endmodule
